// ===== src/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared widths, codes and types of the distance to parameter lookup unit.
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int FRAC_BITS    = 16;

  localparam int SEG_W     = $clog2(MAX_SEGMENTS);
  localparam int CNT_W     = 7;
  localparam int LEN_W     = 32;
  localparam int CTRL_W    = 18;
  localparam int T_FRAC    = 16;
  localparam int T_W       = T_FRAC + 1;
  localparam int X_W       = FRAC_BITS + 1;
  localparam int DIV_STEPS = FRAC_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W = 1;

  localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC{1'b0}}};
  localparam logic [X_W-1:0] X_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 1'b1;

  localparam logic [LEN_W-1:0] TOTAL_LENGTH_RST  = 32'h0001_0000;
  localparam logic [CNT_W-1:0] SEGMENT_COUNT_RST = 7'd1;

  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_QUERY,
    KIND_LOW,
    KIND_HIGH
  } kind_t;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_LOW    = 2'd1,
    ST_HIGH   = 2'd2
  } clamp_t;

  typedef struct packed {
    kind_t                     kind;
    logic [SEG_W-1:0]          seg;
    logic signed [CTRL_W-1:0]  c1;
    logic signed [CTRL_W-1:0]  c2;
    logic [T_W-1:0]            knot;
    logic [CNT_W-1:0]          n;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic [LEN_W-1:0]  distance;
  } entry_t;

endpackage

// ===== src/dtp_front.sv =====
// ----------------------------------------------------------------------------
// dtp_front
// Classifies an incoming item: table write, clamped query or interpolated query.
// ----------------------------------------------------------------------------
module dtp_front (
  input  logic                                    req_type,
  input  logic [dtp_pkg::SEG_W-1:0]               seg_index,
  input  logic signed [dtp_pkg::CTRL_W-1:0]       ctrl_first,
  input  logic signed [dtp_pkg::CTRL_W-1:0]       ctrl_second,
  input  logic [dtp_pkg::T_W-1:0]                 knot_end,
  input  logic signed [dtp_pkg::LEN_W-1:0]        distance,
  input  logic [dtp_pkg::LEN_W-1:0]               total_length,
  input  logic [dtp_pkg::CNT_W-1:0]               segment_count,
  output dtp_pkg::entry_t                         entry
);

  logic [dtp_pkg::CNT_W-1:0] n_eff;
  logic [dtp_pkg::CNT_W-1:0] n_last;

  always_comb begin
    if (segment_count == '0) begin
      n_eff = dtp_pkg::CNT_W'(1);
    end else if (segment_count > dtp_pkg::CNT_W'(dtp_pkg::MAX_SEGMENTS)) begin
      n_eff = dtp_pkg::CNT_W'(dtp_pkg::MAX_SEGMENTS);
    end else begin
      n_eff = segment_count;
    end
    n_last = n_eff - dtp_pkg::CNT_W'(1);
  end

  always_comb begin
    entry.distance    = distance;
    entry.item.seg    = seg_index;
    entry.item.c1     = ctrl_first;
    entry.item.c2     = ctrl_second;
    entry.item.knot   = knot_end;
    entry.item.n      = n_eff;
    if (dtp_pkg::req_t'(req_type) == dtp_pkg::REQ_WRITE) begin
      entry.item.kind = dtp_pkg::KIND_WRITE;
    end else if (distance <= 0) begin
      entry.item.kind = dtp_pkg::KIND_LOW;
      entry.item.seg  = '0;
    end else if (distance >= total_length) begin
      // positive here, so an unsigned compare is exact
      entry.item.kind = dtp_pkg::KIND_HIGH;
      entry.item.seg  = n_last[dtp_pkg::SEG_W-1:0];
    end else begin
      entry.item.kind = dtp_pkg::KIND_QUERY;
    end
  end

endmodule

// ===== src/dtp_queue.sv =====
// ----------------------------------------------------------------------------
// dtp_queue
// Short FIFO between the classifier and the evaluation pipeline.
// ----------------------------------------------------------------------------
module dtp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  dtp_pkg::entry_t  push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output dtp_pkg::entry_t  pop_entry
);

  dtp_pkg::entry_t                mem_r [dtp_pkg::QUEUE_DEPTH];
  logic [dtp_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [dtp_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [dtp_pkg::QPTR_W:0]       count_r;
  logic                           push;
  logic                           pop;

  assign push_ready = (count_r != (dtp_pkg::QPTR_W+1)'(dtp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + dtp_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + dtp_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (dtp_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (dtp_pkg::QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== src/dtp_back.sv =====
// ----------------------------------------------------------------------------
// dtp_back
// Evaluation pipeline: bit-per-stage divider, segment table, cubic weights,
// blend and knot scaling. The whole pipeline advances together.
// ----------------------------------------------------------------------------
module dtp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dtp_pkg::entry_t               in_entry,
  input  logic [dtp_pkg::LEN_W-1:0]     total_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dtp_pkg::T_W-1:0]       out_param,
  output dtp_pkg::clamp_t               out_status,
  output logic [dtp_pkg::SEG_W-1:0]     out_seg
);

  localparam int DS    = dtp_pkg::DIV_STEPS;
  localparam int X_W   = dtp_pkg::X_W;
  localparam int FB    = dtp_pkg::FRAC_BITS;
  localparam int CW    = dtp_pkg::CTRL_W;
  localparam int T_W   = dtp_pkg::T_W;
  localparam int SEG_W = dtp_pkg::SEG_W;
  localparam int CNT_W = dtp_pkg::CNT_W;
  localparam int LEN_W = dtp_pkg::LEN_W;
  localparam int SC_W  = CNT_W + DS;
  localparam int W3_W  = X_W + 2;
  localparam int P_W   = W3_W + 1 + CW;
  localparam int Y_W   = P_W + 2;
  localparam int D_W   = T_W + 1;
  localparam int PR_W  = Y_W + D_W;
  localparam int SH    = FB + dtp_pkg::T_FRAC;
  localparam int R_W   = PR_W + 1 - SH;
  localparam int TS_W  = R_W + 1;
  localparam logic signed [PR_W:0] RND = (PR_W+1)'(1) << (SH - 1);

  logic adv;

  // divider stages
  logic                 div_v_r    [DS+1];
  dtp_pkg::item_t       div_item_r [DS+1];
  logic [LEN_W-1:0]     div_rem_r  [DS+1];
  logic [DS-1:0]        div_q_r    [DS+1];
  logic [LEN_W-1:0]     rem_nxt    [DS+1];
  logic [DS-1:0]        q_nxt      [DS+1];

  // segment select
  logic [SC_W-1:0]      scaled;
  logic [CNT_W-1:0]     k_full;
  logic [CNT_W-1:0]     n_last;
  logic [SEG_W-1:0]     k_sel;
  logic [X_W-1:0]       x_sel;
  dtp_pkg::item_t       sel_item;
  logic [SEG_W-1:0]     rd_prev;

  // table
  logic signed [CW-1:0] c1_mem [dtp_pkg::MAX_SEGMENTS];
  logic signed [CW-1:0] c2_mem [dtp_pkg::MAX_SEGMENTS];
  logic [T_W-1:0]       kn_mem [dtp_pkg::MAX_SEGMENTS];
  logic signed [CW-1:0] c1_rd_r;
  logic signed [CW-1:0] c2_rd_r;
  logic [T_W-1:0]       kn_rd_r;
  logic [T_W-1:0]       kp_rd_r;

  logic                 a_v_r;
  dtp_pkg::item_t       a_item_r;
  logic [X_W-1:0]       a_x_r;
  logic                 a_first_r;

  logic                 b_v_r;
  dtp_pkg::item_t       b_item_r;
  logic [X_W-1:0]       b_x_r;
  logic [X_W-1:0]       b_uu_r, b_ux_r, b_xx_r;
  logic [T_W-1:0]       b_tprev_r;
  logic signed [D_W-1:0] b_tdiff_r;
  logic signed [CW-1:0] b_c1_r, b_c2_r;
  logic [X_W-1:0]       u_a;
  logic [2*X_W-1:0]     uu_p, ux_p, xx_p;
  logic [T_W-1:0]       tprev_a;

  logic                 c_v_r;
  dtp_pkg::item_t       c_item_r;
  logic [X_W-1:0]       c_w1_r, c_w2_r, c_w3_r;
  logic [T_W-1:0]       c_tprev_r;
  logic signed [D_W-1:0] c_tdiff_r;
  logic signed [CW-1:0] c_c1_r, c_c2_r;
  logic [2*X_W-1:0]     w1_p, w2_p, w3_p;

  logic                 d_v_r;
  dtp_pkg::item_t       d_item_r;
  logic signed [P_W-1:0] d_p1_r, d_p2_r;
  logic [X_W-1:0]       d_w3_r;
  logic [T_W-1:0]       d_tprev_r;
  logic signed [D_W-1:0] d_tdiff_r;
  logic [W3_W-1:0]      w1x3, w2x3;

  logic                 e_v_r;
  dtp_pkg::item_t       e_item_r;
  logic signed [Y_W-1:0] e_y_r;
  logic [T_W-1:0]       e_tprev_r;
  logic signed [D_W-1:0] e_tdiff_r;
  logic signed [Y_W-1:0] w3s;

  logic                 f_v_r;
  dtp_pkg::item_t       f_item_r;
  logic signed [PR_W-1:0] f_prod_r;
  logic [T_W-1:0]       f_tprev_r;

  logic signed [PR_W:0] rsum;
  logic signed [R_W-1:0] rnd_q;
  logic signed [TS_W-1:0] t_sum;
  logic [T_W-1:0]       t_sat;

  logic                 out_valid_r;
  logic [T_W-1:0]       out_param_r;
  dtp_pkg::clamp_t      out_status_r;
  logic [SEG_W-1:0]     out_seg_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid  = out_valid_r;
  assign out_param  = out_param_r;
  assign out_status = out_status_r;
  assign out_seg    = out_seg_r;

  // one quotient bit per stage
  always_comb begin
    logic [LEN_W:0] r2;
    logic           ge;
    rem_nxt[0] = in_entry.distance;
    q_nxt[0]   = '0;
    for (int j = 1; j <= DS; j++) begin
      r2 = {div_rem_r[j-1], 1'b0};
      ge = (r2 >= {1'b0, total_length});
      rem_nxt[j] = ge ? LEN_W'(r2 - {1'b0, total_length}) : r2[LEN_W-1:0];
      q_nxt[j]   = {div_q_r[j-1][DS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= DS; j++) begin
        div_v_r[j] <= 1'b0;
      end
    end else if (adv) begin
      div_v_r[0] <= in_valid;
      for (int j = 1; j <= DS; j++) begin
        div_v_r[j] <= div_v_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_item_r[0] <= in_entry.item;
      div_rem_r[0]  <= rem_nxt[0];
      div_q_r[0]    <= q_nxt[0];
      for (int j = 1; j <= DS; j++) begin
        div_item_r[j] <= div_item_r[j-1];
        div_rem_r[j]  <= rem_nxt[j];
        div_q_r[j]    <= q_nxt[j];
      end
    end
  end

  // segment and local fraction
  always_comb begin
    sel_item = div_item_r[DS];
    scaled   = SC_W'(sel_item.n) * SC_W'(div_q_r[DS]);
    k_full   = scaled[SC_W-1:FB];
    n_last   = sel_item.n - CNT_W'(1);
    if (k_full > n_last) begin
      k_sel = n_last[SEG_W-1:0];
      x_sel = dtp_pkg::X_ONE;
    end else begin
      k_sel = k_full[SEG_W-1:0];
      x_sel = {1'b0, scaled[FB-1:0]};
    end
    if (sel_item.kind == dtp_pkg::KIND_QUERY) begin
      sel_item.seg = k_sel;
    end
    rd_prev = k_sel - SEG_W'(1);
  end

  always_ff @(posedge clk) begin
    if (adv && div_v_r[DS] && div_item_r[DS].kind == dtp_pkg::KIND_WRITE) begin
      c1_mem[div_item_r[DS].seg] <= div_item_r[DS].c1;
      c2_mem[div_item_r[DS].seg] <= div_item_r[DS].c2;
      kn_mem[div_item_r[DS].seg] <= div_item_r[DS].knot;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_rd_r <= c1_mem[k_sel];
      c2_rd_r <= c2_mem[k_sel];
      kn_rd_r <= kn_mem[k_sel];
      kp_rd_r <= kn_mem[rd_prev];
    end
  end

  // squares and cross term
  always_comb begin
    u_a     = dtp_pkg::X_ONE - a_x_r;
    uu_p    = u_a * u_a;
    ux_p    = u_a * a_x_r;
    xx_p    = a_x_r * a_x_r;
    tprev_a = a_first_r ? '0 : kp_rd_r;
  end

  // cubic weights
  always_comb begin
    w1_p = b_uu_r * b_x_r;
    w2_p = b_ux_r * b_x_r;
    w3_p = b_xx_r * b_x_r;
  end

  always_comb begin
    w1x3 = W3_W'(c_w1_r) + W3_W'({c_w1_r, 1'b0});
    w2x3 = W3_W'(c_w2_r) + W3_W'({c_w2_r, 1'b0});
  end

  always_comb begin
    w3s = $signed(Y_W'({d_w3_r, {dtp_pkg::T_FRAC{1'b0}}}));
  end

  // round half up, add the start knot, saturate
  always_comb begin
    rsum  = $signed({f_prod_r[PR_W-1], f_prod_r}) + RND;
    rnd_q = rsum[PR_W:SH];
    t_sum = $signed(TS_W'(f_tprev_r)) + TS_W'(rnd_q);
    if (t_sum < 0) begin
      t_sat = '0;
    end else if (t_sum > $signed(TS_W'(dtp_pkg::T_ONE))) begin
      t_sat = dtp_pkg::T_ONE;
    end else begin
      t_sat = t_sum[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
      e_v_r       <= 1'b0;
      f_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_v_r       <= div_v_r[DS];
      b_v_r       <= a_v_r;
      c_v_r       <= b_v_r;
      d_v_r       <= c_v_r;
      e_v_r       <= d_v_r;
      f_v_r       <= e_v_r;
      out_valid_r <= f_v_r && (f_item_r.kind != dtp_pkg::KIND_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item_r  <= sel_item;
      a_x_r     <= x_sel;
      a_first_r <= (k_sel == '0);

      b_item_r  <= a_item_r;
      b_x_r     <= a_x_r;
      b_uu_r    <= uu_p[FB +: X_W];
      b_ux_r    <= ux_p[FB +: X_W];
      b_xx_r    <= xx_p[FB +: X_W];
      b_tprev_r <= tprev_a;
      b_tdiff_r <= $signed({1'b0, kn_rd_r}) - $signed({1'b0, tprev_a});
      b_c1_r    <= c1_rd_r;
      b_c2_r    <= c2_rd_r;

      c_item_r  <= b_item_r;
      c_w1_r    <= w1_p[FB +: X_W];
      c_w2_r    <= w2_p[FB +: X_W];
      c_w3_r    <= w3_p[FB +: X_W];
      c_tprev_r <= b_tprev_r;
      c_tdiff_r <= b_tdiff_r;
      c_c1_r    <= b_c1_r;
      c_c2_r    <= b_c2_r;

      d_item_r  <= c_item_r;
      d_p1_r    <= $signed({1'b0, w1x3}) * c_c1_r;
      d_p2_r    <= $signed({1'b0, w2x3}) * c_c2_r;
      d_w3_r    <= c_w3_r;
      d_tprev_r <= c_tprev_r;
      d_tdiff_r <= c_tdiff_r;

      e_item_r  <= d_item_r;
      e_y_r     <= Y_W'(d_p1_r) + Y_W'(d_p2_r) + w3s;
      e_tprev_r <= d_tprev_r;
      e_tdiff_r <= d_tdiff_r;

      f_item_r  <= e_item_r;
      f_prod_r  <= e_y_r * e_tdiff_r;
      f_tprev_r <= e_tprev_r;

      out_seg_r <= f_item_r.seg;
      case (f_item_r.kind)
        dtp_pkg::KIND_LOW: begin
          out_param_r  <= '0;
          out_status_r <= dtp_pkg::ST_LOW;
        end
        dtp_pkg::KIND_HIGH: begin
          out_param_r  <= dtp_pkg::T_ONE;
          out_status_r <= dtp_pkg::ST_HIGH;
        end
        default: begin
          out_param_r  <= t_sat;
          out_status_r <= dtp_pkg::ST_INTERP;
        end
      endcase
    end
  end

  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == dtp_pkg::ST_LOW |-> out_param_r == '0 && out_seg_r == '0)
    else $error("clamped-low result not zero");

  a_high_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == dtp_pkg::ST_HIGH |-> out_param_r == dtp_pkg::T_ONE)
    else $error("clamped-high result not one");

  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_param_r <= dtp_pkg::T_ONE)
    else $error("param_t above one");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && f_v_r && f_item_r.kind == dtp_pkg::KIND_WRITE |=> !out_valid_r)
    else $error("table write produced a result");

endmodule

// ===== src/distance_to_param_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// distance_to_param_lookup_unit
// Maps an arc-length distance to curve parameter t through a segment table.
// ----------------------------------------------------------------------------
//  port group | direction | carries
//  in_*       | slave     | table writes and distance queries
//  out_*      | master    | param_t, segment_used, clamp_status
//  cfg_*      | write     | total_length (index 0), segment_count (index 1)
//
// One item per cycle sustained while out_tready is high; a query result
// passes through the 16-stage one-bit-per-stage divider and then 7 stages
// of table read, weights, blend and knot scaling. A 4-entry queue separates
// input acceptance from the pipeline; out_tready low stalls the pipeline
// and the queue fills. Reset is synchronous and does not clear the segment
// table, which is unknown until written. Table writes give no transfer out.
// ----------------------------------------------------------------------------
module distance_to_param_lookup_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // seg_index[5:0], ctrl_first[23:6], ctrl_second[41:24], knot_end[58:42],
  // distance[90:59], zero pad [95:91]
  input  logic [95:0]  in_tdata,
  // req_type[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // param_t[16:0], segment_used[22:17], zero pad [23]
  output logic [23:0]  out_tdata,
  // clamp_status[1:0]
  output logic [1:0]   out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dtp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);

  logic [dtp_pkg::LEN_W-1:0] total_length_r;
  logic [dtp_pkg::CNT_W-1:0] segment_count_r;
  dtp_pkg::entry_t           front_entry;
  dtp_pkg::entry_t           q_entry;
  logic                      q_valid;
  logic                      q_ready;
  logic [dtp_pkg::T_W-1:0]   param_t;
  logic [dtp_pkg::SEG_W-1:0] segment_used;
  dtp_pkg::clamp_t           clamp_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_length_r  <= dtp_pkg::TOTAL_LENGTH_RST;
      segment_count_r <= dtp_pkg::SEGMENT_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtp_pkg::CFG_TOTAL_LENGTH:  total_length_r  <= cfg_data;
        dtp_pkg::CFG_SEGMENT_COUNT: segment_count_r <= cfg_data[dtp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  dtp_front u_front (
    .req_type      (in_tuser),
    .seg_index     (in_tdata[5:0]),
    .ctrl_first    (in_tdata[23:6]),
    .ctrl_second   (in_tdata[41:24]),
    .knot_end      (in_tdata[58:42]),
    .distance      (in_tdata[90:59]),
    .total_length  (total_length_r),
    .segment_count (segment_count_r),
    .entry         (front_entry)
  );

  dtp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_entry (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  dtp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_entry     (q_entry),
    .total_length (total_length_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_param    (param_t),
    .out_status   (clamp_status),
    .out_seg      (segment_used)
  );

  assign out_tdata = {1'b0, segment_used, param_t};
  assign out_tuser = clamp_status;

endmodule

// ===== sim/distance_to_param_lookup_unit_tb.sv =====
// ----------------------------------------------------------------------------
// distance_to_param_lookup_unit_tb
// Streams segment writes and distance queries into the lookup unit under
// random gaps and back-pressure, predicts each parameter result in fixed
// point and compares its t, seg and clamp fields. Runs several length/count settings.
// ----------------------------------------------------------------------------
module distance_to_param_lookup_unit_tb;

  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [16:0] t;
    logic [5:0]  seg;
    logic [1:0]  clamp;
  } param_res_t;

  typedef struct packed {
    logic        is_query;
    logic [95:0] data;
  } lookup_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [dtp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  distance_to_param_lookup_unit DUT (.*);

  // predictor state
  logic [31:0]        len_reg;
  logic [6:0]         count_reg;
  logic signed [17:0] c1_tab [dtp_pkg::MAX_SEGMENTS];
  logic signed [17:0] c2_tab [dtp_pkg::MAX_SEGMENTS];
  logic [16:0]        knot_tab [dtp_pkg::MAX_SEGMENTS];

  lookup_req_t pending_reqs[$];
  param_res_t  expected_params[$];
  int          mismatches = 0;
  int          cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int short_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_req(lookup_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void add_expected(param_res_t r);
    expected_params.insert(expected_params.size(), r);
  endfunction

  function automatic param_res_t predict_param(logic [95:0] d);
    param_res_t res;
    logic signed [31:0] qdist;
    longint unsigned n, dn, scaled, k, x, u, w1, w2, w3;
    longint y, tprev, tdiff, t, p;
    qdist = d[90:59];
    n = (count_reg == 0) ? 1 :
        (count_reg > dtp_pkg::MAX_SEGMENTS ? dtp_pkg::MAX_SEGMENTS : count_reg);
    if (qdist <= 0) begin
      res = '{17'd0, 6'd0, dtp_pkg::ST_LOW};
      return res;
    end
    if (longint'(unsigned'(qdist)) >= longint'(len_reg)) begin
      res.t = 17'h10000; res.seg = 6'(n - 1); res.clamp = dtp_pkg::ST_HIGH;
      return res;
    end
    dn = (longint'(unsigned'(qdist)) << 16) / longint'(len_reg);
    scaled = n * dn;
    k = scaled >> 16;
    if (k > n - 1) begin
      k = n - 1; x = 65536;
    end else begin
      x = scaled - (k << 16);
    end
    u = 65536 - x;
    w1 = (((u * u) >> 16) * x) >> 16;
    w2 = (((u * x) >> 16) * x) >> 16;
    w3 = (((x * x) >> 16) * x) >> 16;
    y = 3 * longint'(w1) * longint'(c1_tab[k]) + 3 * longint'(w2) * longint'(c2_tab[k])
      + longint'(w3 << 16);
    tprev = (k == 0) ? 0 : longint'(knot_tab[k - 1]);
    tdiff = longint'(knot_tab[k]) - tprev;
    p = y * tdiff + (longint'(1) <<< 31);
    t = tprev + (p >>> 32);
    if (t < 0) t = 0;
    if (t > 65536) t = 65536;
    res.t = 17'(t); res.seg = 6'(k); res.clamp = dtp_pkg::ST_INTERP;
    return res;
  endfunction

  function automatic lookup_req_t make_write(int seg, int c1, int c2, int knot);
    lookup_req_t r;
    r.is_query = dtp_pkg::REQ_WRITE;
    r.data = '0;
    r.data[5:0] = 6'(seg);
    r.data[23:6] = 18'(c1);
    r.data[41:24] = 18'(c2);
    r.data[58:42] = 17'(knot);
    r.data[90:59] = $urandom;
    return r;
  endfunction

  function automatic lookup_req_t make_query(logic [31:0] qdist);
    lookup_req_t r;
    r.is_query = dtp_pkg::REQ_QUERY;
    r.data = '0;
    r.data[58:0] = 59'({$urandom, $urandom});
    r.data[90:59] = qdist;
    return r;
  endfunction

  // driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0; in_tdata <= '0; in_tuser <= 1'b0; in_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid && in_tready && pending_reqs.size() > 0) begin
        // advance predictor on the accepted transfer
        if (in_tuser == dtp_pkg::REQ_QUERY) add_expected(predict_param(in_tdata));
        else begin
          c1_tab[in_tdata[5:0]] <= in_tdata[23:6];
          c2_tab[in_tdata[5:0]] <= in_tdata[41:24];
          knot_tab[in_tdata[5:0]] <= in_tdata[58:42];
        end
        void'(pending_reqs.pop_front());
      end
      if (in_tvalid && in_tready && in_gap == 0) in_gap <= short_gap();
      if (in_gap > 0 && !(in_tvalid && in_tready)) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (in_gap > 0) begin
        in_tvalid <= 1'b0;
      end else begin
        if (pending_reqs.size() > (in_tvalid && in_tready ? 1 : 0)) begin
          in_tvalid <= 1'b1;
          in_tuser <= pending_reqs[(in_tvalid && in_tready) ? 1 : 0].is_query;
          in_tdata <= pending_reqs[(in_tvalid && in_tready) ? 1 : 0].data;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall
  int out_gap;
  param_res_t got, exp_r;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0; out_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.t = out_tdata[16:0]; got.seg = out_tdata[22:17]; got.clamp = out_tuser;
        if (expected_params.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result t=%0d seg=%0d clamp=%0d",
                                         got.t, got.seg, got.clamp);
        end else begin
          exp_r = expected_params.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp t=%0d seg=%0d clamp=%0d, got t=%0d seg=%0d clamp=%0d",
                       exp_r.t, exp_r.seg, exp_r.clamp, got.t, got.seg, got.clamp);
          end
        end
      end
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= short_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [dtp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == dtp_pkg::CFG_TOTAL_LENGTH) len_reg = val;
    else count_reg = val[6:0];
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_params.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // fill all segments so no unwritten entry is ever read
  task automatic load_table(bit extremes);
    int knot, c1, c2;
    knot = 0;
    for (int s = 0; s < dtp_pkg::MAX_SEGMENTS; s++) begin
      knot = (s == dtp_pkg::MAX_SEGMENTS - 1) ? 65536 : $urandom_range(0, 65536);
      if (extremes) begin
        c1 = (s % 2) ? -131072 : 131071;
        c2 = (s % 2) ? 131071 : -131072;
      end else begin
        c1 = $urandom_range(0, 262143) - 131072;
        c2 = $urandom_range(0, 262143) - 131072;
      end
      add_req(make_write(s, c1, c2, knot));
    end
  endtask

  function automatic logic [31:0] rand_dist();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return 32'(-$urandom_range(0, 1000));
    if (r == 2) return len_reg + $urandom_range(0, 3);
    return (len_reg <= 2) ? 32'd1 : 32'($urandom_range(1, len_reg - 1));
  endfunction

  task automatic run_phase(logic [31:0] len, logic [6:0] cnt, int queries);
    write_reg(dtp_pkg::CFG_TOTAL_LENGTH, len);
    write_reg(dtp_pkg::CFG_SEGMENT_COUNT, {25'd0, cnt});
    for (int i = 0; i < queries; i++) begin
      if ($urandom_range(0, 15) == 0)
        add_req(make_write($urandom_range(0, 63),
          $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072,
          $urandom_range(0, 65536)));
      else add_req(make_query(rand_dist()));
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    len_reg = dtp_pkg::TOTAL_LENGTH_RST; count_reg = dtp_pkg::SEGMENT_COUNT_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extreme table, then edge distances
    load_table(1'b1);
    add_req(make_query(32'h0000_0000));
    add_req(make_query(32'h8000_0000));
    add_req(make_query(32'h7FFF_FFFF));
    add_req(make_query(32'h0001_0000));
    add_req(make_query(32'h0000_FFFF));
    add_req(make_query(32'h0000_0001));
    add_req(make_query(32'h0000_8000));
    wait_idle();
    run_phase(32'hFFFF_FFFF, 7'd64, 12);
    run_phase(32'd1, 7'd0, 8);
    run_phase(32'd3, 7'd100, 10);
    run_phase(32'h0040_0000, 7'd127, 15);
    load_table(1'b0);
    wait_idle();
    run_phase(32'h0003_0000, 7'd5, 110);
    run_phase(32'h0000_0100, 7'd64, 110);
    run_phase(32'h1234_5678, 7'd1, 100);
    run_phase(32'hFFFF_FFFF, 7'd33, 100);
    run_phase(32'h0100_0000, 7'd17, 100);
    if (mismatches == 0 && expected_params.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== distance_to_param_lookup_unit.f =====
src/dtp_pkg.sv
src/dtp_front.sv
src/dtp_queue.sv
src/dtp_back.sv
src/distance_to_param_lookup_unit.sv
sim/distance_to_param_lookup_unit_tb.sv
